@@ sv/rbd2x_pkg.sv @@
// Package with the types, constants and channel arithmetic of the 2x2 RGB565 downscaler.
package rbd2x_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [9:0] RST_SRC_WIDTH  = 10'd512;
  localparam logic [9:0] RST_SRC_HEIGHT = 10'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DEST_X     = 2'd2,
    REG_DEST_Y     = 2'd3
  } cfg_reg_t;

  // RGB565 field layout.
  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;
  localparam logic [4:0] RED_MASK   = 5'h1F;
  localparam logic [5:0] GREEN_MASK = 6'h3F;
  localparam logic [4:0] BLUE_MASK  = 5'h1F;

  // Horizontal pair sums as kept in the line buffer.
  typedef struct packed {
    logic [5:0] red;
    logic [6:0] green;
    logic [5:0] blue;
  } pair_sum_t;

  function automatic pair_sum_t pack_pair(input logic [15:0] a, input logic [15:0] b);
    pair_sum_t s;
    s.red   = {1'b0, a[RED_LSB +: 5] & RED_MASK} + {1'b0, b[RED_LSB +: 5] & RED_MASK};
    s.green = {1'b0, a[GREEN_LSB +: 6] & GREEN_MASK} + {1'b0, b[GREEN_LSB +: 6] & GREEN_MASK};
    s.blue  = {1'b0, a[4:0] & BLUE_MASK} + {1'b0, b[4:0] & BLUE_MASK};
    return s;
  endfunction

  // Adds the two rows of a 2x2 block and divides by four with truncation.
  function automatic logic [15:0] average_block(input pair_sum_t top, input pair_sum_t bot);
    logic [6:0] r;
    logic [7:0] g;
    logic [6:0] b;
    r = {1'b0, top.red} + {1'b0, bot.red};
    g = {1'b0, top.green} + {1'b0, bot.green};
    b = {1'b0, top.blue} + {1'b0, bot.blue};
    return {r[6:2], g[7:2], b[6:2]};
  endfunction

endpackage

@@ sv/rgb565_box_downscale_2x_top.sv @@
// Top level of the 2x2 box-filter RGB565 downscaler with its line buffer.
// Pixels enter in raster order at up to one request per clock unless stalled,
// with no bubbles at row or frame boundaries. Even source rows store the
// horizontal pair sums in a line buffer of MAX_WIDTH/2 entries; on odd rows the
// stored sum for a pair is read when its even-column pixel is taken, so it is
// ready when the partner arrives, and the odd-column request loads one averaged
// pixel into an output register. The buffer sees at most one access per cycle.
// There is no clearing pass after reset: the first frame must start at row zero.
// An odd last row or column produces nothing; sizes are clamped to
// [2, MAX_WIDTH] and [2, MAX_HEIGHT]; write configuration only while idle.
module rgb565_box_downscale_2x_top
  import rbd2x_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_src_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_pixel,
  output logic [9:0]            out_x,
  output logic [9:0]            out_y,
  output logic                  out_frame_last
);

  localparam int PAIRS = MAX_WIDTH / 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int SW0   = $clog2(MAX_WIDTH + 1);
  localparam int SH0   = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = (SW0 > CFG_DATA_W) ? SW0 : CFG_DATA_W;
  localparam int SH    = (SH0 > CFG_DATA_W) ? SH0 : CFG_DATA_W;

  // Configuration registers.
  logic [9:0] src_width_r, src_height_r;
  logic [8:0] dest_x_r, dest_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      dest_x_r     <= '0;
      dest_y_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        REG_DEST_X:     dest_x_r     <= cfg_wdata[8:0];
        REG_DEST_Y:     dest_y_r     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] width_c;
  logic [SH-1:0] height_c;

  always_comb begin
    if (src_width_r < 10'd2) width_c = SW'(2);
    else if (SW'(src_width_r) > SW'(MAX_WIDTH)) width_c = SW'(MAX_WIDTH);
    else width_c = SW'(src_width_r);
    if (src_height_r < 10'd2) height_c = SH'(2);
    else if (SH'(src_height_r) > SH'(MAX_HEIGHT)) height_c = SH'(MAX_HEIGHT);
    else height_c = SH'(src_height_r);
  end

  // Raster position counters.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [SW-1:0] col_inc;
  logic [SH-1:0] row_inc;
  logic          in_fire;

  assign in_fire = in_valid && in_ready;
  assign col_inc = SW'(col_r) + SW'(1);
  assign row_inc = SH'(row_r) + SH'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_inc >= width_c) begin
        col_nxt = '0;
        row_nxt = (row_inc >= height_c) ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffer of pair sums, one port access per cycle.
  logic      [AW-1:0] pair;
  logic               odd_col, odd_row;
  logic               buf_wr, buf_rd;
  pair_sum_t          line_buf [PAIRS];
  pair_sum_t          rd_data_r;
  pair_sum_t          sums;
  logic      [15:0]   held_r;

  assign pair    = AW'(col_r >> 1);
  assign odd_col = col_r[0];
  assign odd_row = row_r[0];
  assign sums    = pack_pair(held_r, in_src_pixel);
  assign buf_wr  = in_fire && odd_col && !odd_row;
  assign buf_rd  = in_fire && !odd_col && odd_row;

  always_ff @(posedge clk) begin
    if (buf_wr) line_buf[pair] <= sums;
    if (buf_rd) rd_data_r <= line_buf[pair];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= '0;
    else if (in_fire && !odd_col) held_r <= in_src_pixel;
  end

  // Output register; a new request is taken whenever it is empty or draining.
  logic       out_valid_r;
  logic       emit;
  logic [15:0] out_pixel_r;
  logic [9:0]  out_x_r, out_y_r;
  logic        out_last_r;
  logic        last_col, last_row;

  assign in_ready = !out_valid_r || out_ready;
  assign emit     = in_fire && odd_col && odd_row;
  assign last_col = (SW'(pair) == (width_c >> 1) - SW'(1));
  assign last_row = (SH'(row_r >> 1) == (height_c >> 1) - SH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_r <= average_block(rd_data_r, sums);
      out_x_r     <= {1'b0, dest_x_r} + 10'(pair);
      out_y_r     <= {1'b0, dest_y_r} + 10'(row_r >> 1);
      out_last_r  <= last_col && last_row;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_frame_last = out_last_r;

endmodule

@@ sv/rbd2x_checker.sv @@
// Port-level checker for the downscaler and its bind to the top level.
module rbd2x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel,
  input logic [9:0]  out_x,
  input logic [9:0]  out_y,
  input logic        out_frame_last
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_x)
                               && $stable(out_y) && $stable(out_frame_last))
    else $error("stalled result changed");

  // With no pending result the block must be able to take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // A result only appears after a request was taken.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without request");

  // A drained result with no new request leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated");

endmodule

bind rgb565_box_downscale_2x_top rbd2x_checker u_rbd2x_checker (.*);
